@@ rtl/flit_bit_fault_injector_defines.svh @@
// assertion macros for the flit bit fault injector
`ifndef FLIT_BIT_FAULT_INJECTOR_DEFINES_SVH
`define FLIT_BIT_FAULT_INJECTOR_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define FBFI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define FBFI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/fbfi_pkg.sv @@
`default_nettype none
package fbfi_pkg;

	localparam int DATA_BITS_DEF     = 32;
	localparam int DURATION_BITS_DEF = 8;

	// width of the fixed item fields
	localparam int VEC_W  = 32;
	localparam int WIRE_W = 5;
	localparam int FW_W   = 6;
	localparam int DUR_W  = 8;

	typedef enum logic [1:0] {
		MODE_BUFFER = 2'd0,
		MODE_LINK   = 2'd1,
		MODE_XFER   = 2'd2
	} fbfi_mode_t;

	// control from the item stage to the lasting flip counters
	typedef struct packed {
		logic load;
		logic decay;
	} fbfi_cnt_ctl_t;

endpackage
`default_nettype wire

@@ rtl/flit_bit_fault_injector.sv @@
// flit bit fault injector
// input channel (in_valid/in_ready) carries one item a transfer: mode selects a
// buffer fault, a link fault or a flit transfer. fault items update the pending
// flip masks and the per-bit lasting counters and give no result. a flit transfer
// gives one result on the output channel (out_valid/out_ready): the flit's error
// vector with all pending and lasting flips applied.
// config channel (cfg_valid/cfg_ready) writes is_output_port; write it only while
// no item is in flight. link faults are dropped on an input port.
// an accepted transfer waits in the item register, is then registered into the
// result register and is taken from there by the receiver.
// throughput: one item per cycle unless stalled; the item register feeds a single
// pass of window decode, mask update and counter update into the result register.
// when the receiver stalls, fault items keep flowing; a second transfer waits in
// the item register until the result register is taken, and in_ready drops.
// reset clears all masks, all lasting counters, the port kind and both valids.
`default_nettype none
`include "flit_bit_fault_injector_defines.svh"
module flit_bit_fault_injector import fbfi_pkg::*; #(
	parameter int DATA_BITS     = DATA_BITS_DEF,
	parameter int DURATION_BITS = DURATION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              is_output_port,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        mode,
	input  logic [VEC_W-1:0]  error_vector,
	input  logic [WIRE_W-1:0] fault_wire,
	input  logic [FW_W-1:0]   fault_width,
	input  logic [DUR_W-1:0]  fault_duration,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [VEC_W-1:0]  error_vector_out
);

	logic                 port_q;
	logic                 valid_s1;
	logic [1:0]           mode_s1;
	logic [VEC_W-1:0]     ev_s1;
	logic [WIRE_W-1:0]    wire_s1;
	logic [FW_W-1:0]      width_s1;
	logic [DUR_W-1:0]     dur_s1;
	logic [DATA_BITS-1:0] buf_q;
	logic [DATA_BITS-1:0] link_q;
	logic [DATA_BITS-1:0] touched_q;
	logic                 out_valid_q;
	logic [VEC_W-1:0]     out_q;
	logic [DATA_BITS-1:0] win;
	logic [DATA_BITS-1:0] lasting;
	logic [DATA_BITS-1:0] flip_all;
	logic                 advance;
	logic                 is_buf;
	logic                 is_link;
	logic                 is_xfer;
	fbfi_cnt_ctl_t        cnt_ctl;

	assign cfg_ready        = 1'b1;
	assign out_valid        = out_valid_q;
	assign error_vector_out = out_q;

	always_comb begin
		is_buf   = (mode_s1 == MODE_BUFFER);
		is_link  = (mode_s1 == MODE_LINK) && port_q;
		is_xfer  = (mode_s1 == MODE_XFER);
		// only a transfer needs room in the result register
		advance  = valid_s1 && (!is_xfer || !out_valid_q || out_ready);
		in_ready = !valid_s1 || advance;
		cnt_ctl.load  = advance && is_link;
		cnt_ctl.decay = advance && is_xfer && port_q;
		flip_all = buf_q ^ (port_q ? (link_q ^ lasting) : '0);
	end

	fbfi_window #(
		.DATA_BITS(DATA_BITS)
	) u_window (
		.wire_sel(wire_s1),
		.width   (width_s1),
		.win     (win)
	);

	fbfi_lasting #(
		.DATA_BITS    (DATA_BITS),
		.DURATION_BITS(DURATION_BITS)
	) u_lasting (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cnt_ctl),
		.win     (win),
		.touched (touched_q),
		.duration(dur_s1),
		.flip    (lasting)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			port_q <= is_output_port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1  <= mode;
			ev_s1    <= error_vector;
			wire_s1  <= fault_wire;
			width_s1 <= fault_width;
			dur_s1   <= fault_duration;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q     <= '0;
			link_q    <= '0;
			touched_q <= '0;
		end else if (advance) begin
			if (is_xfer) begin
				buf_q     <= '0;
				link_q    <= '0;
				touched_q <= '0;
			end else if (is_buf) begin
				buf_q <= buf_q ^ win;
			end else if (is_link) begin
				link_q    <= link_q ^ win;
				touched_q <= touched_q | win;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_xfer) begin
			out_q <= ev_s1 ^ VEC_W'(flip_all);
		end
	end

	`FBFI_ASSERT_NEXT(a_xfer_gives_result, advance && is_xfer, out_valid_q,
		"transfer gave no result")
	`FBFI_ASSERT_NEXT(a_xfer_clears_masks, advance && is_xfer,
		buf_q == '0 && link_q == '0 && touched_q == '0, "masks not cleared after transfer")
	`FBFI_ASSERT_NEXT(a_held_item_kept, !in_ready, valid_s1, "held item lost")
	`FBFI_ASSERT_NEXT(a_input_port_no_link, advance && mode_s1 == MODE_LINK && !port_q,
		$stable(link_q) && $stable(touched_q), "link fault taken on input port")

endmodule
`default_nettype wire

@@ rtl/fbfi_window.sv @@
`default_nettype none
module fbfi_window import fbfi_pkg::*; #(
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input  logic [WIRE_W-1:0]    wire_sel,
	input  logic [FW_W-1:0]      width,
	output logic [DATA_BITS-1:0] win
);

	localparam int IW = $clog2(DATA_BITS + 64) + 1;

	logic [IW-1:0] width_ext;
	logic [IW-1:0] w;
	logic [IW-1:0] half;
	logic [IW-1:0] c_ext;
	logic [IW-1:0] begin_raw;
	logic [IW-1:0] lo;
	logic [IW-1:0] hi;

	always_comb begin
		width_ext = IW'(width);
		w         = (width_ext > IW'(DATA_BITS)) ? IW'(DATA_BITS) : width_ext;
		half      = w >> 1;
		c_ext     = IW'(wire_sel);
		begin_raw = (c_ext >= half) ? c_ext - half : '0;
		// slide the window down when it would run past the top bit
		lo        = (begin_raw + w > IW'(DATA_BITS)) ? IW'(DATA_BITS) - w : begin_raw;
		hi        = lo + w;
		for (int i = 0; i < DATA_BITS; i++) begin
			win[i] = (IW'(i) >= lo) && (IW'(i) < hi);
		end
	end

endmodule
`default_nettype wire

@@ rtl/fbfi_lasting.sv @@
`default_nettype none
module fbfi_lasting import fbfi_pkg::*; #(
	parameter int DATA_BITS     = DATA_BITS_DEF,
	parameter int DURATION_BITS = DURATION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fbfi_cnt_ctl_t        ctl,
	input  logic [DATA_BITS-1:0] win,
	input  logic [DATA_BITS-1:0] touched,
	input  logic [DUR_W-1:0]     duration,
	output logic [DATA_BITS-1:0] flip
);

	localparam int LW = (DURATION_BITS > DUR_W) ? DURATION_BITS : DUR_W;
	localparam logic [LW-1:0] CNT_MAX = LW'((1 << DURATION_BITS) - 1);

	logic [DURATION_BITS-1:0] cnt_q [DATA_BITS];
	logic [DUR_W-1:0]         load_raw;
	logic [LW-1:0]            load_ext;
	logic [DURATION_BITS-1:0] load_val;

	always_comb begin
		load_raw = (duration == '0) ? '0 : duration - DUR_W'(1);
		load_ext = LW'(load_raw);
		load_val = DURATION_BITS'((load_ext > CNT_MAX) ? CNT_MAX : load_ext);
		// bits freshly hit by a link fault are not inverted again this transfer
		for (int b = 0; b < DATA_BITS; b++) begin
			flip[b] = (cnt_q[b] != '0) && !touched[b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < DATA_BITS; b++) begin
				cnt_q[b] <= '0;
			end
		end else begin
			for (int b = 0; b < DATA_BITS; b++) begin
				if (ctl.load && win[b]) begin
					cnt_q[b] <= load_val;
				end else if (ctl.decay && flip[b]) begin
					cnt_q[b] <= cnt_q[b] - DURATION_BITS'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire
